// ===== rtl/core/ornt_pkg.sv =====
// ----------------------------------------------------------------------------
// ornt_pkg
// shared widths, constants and control types of the relu neuron trainer
// ----------------------------------------------------------------------------
package ornt_pkg;

  // field widths
  localparam int unsigned FeatW   = 16;
  localparam int unsigned LrW     = 16;
  localparam int unsigned TargetW = 24;
  localparam int unsigned PredW   = 24;
  localparam int unsigned ErrW    = 25;

  // fixed-point formats
  localparam int unsigned FracW   = 16;  // q31.16 fraction bits
  localparam int unsigned WeightW = 48;  // weights, bias, scaled error
  localparam int unsigned SumW    = 56;  // wide dot-product accumulator
  localparam int unsigned ProdW   = 64;  // full 16 x 48 product
  localparam int unsigned HalfW   = 24;  // split point of the 48-bit operand

  // learning rate after reset, about 0.0025 in q0.16
  localparam logic [LrW-1:0] LrReset = LrW'(164);

  // item command
  typedef enum logic {
    CmdTrain   = 1'b0,
    CmdPredict = 1'b1
  } cmd_e;

  // shared multiplier control
  typedef struct packed {
    logic load_lo;  // start a product with the low half of the wide operand
    logic load_hi;  // add the high half partial product
  } mul_ctrl_t;

endpackage

// ===== rtl/core/ornt_in_if.sv =====
// ----------------------------------------------------------------------------
// ornt_in_if
// input channel: one training or prediction item per transaction
// ----------------------------------------------------------------------------
interface ornt_in_if;
  import ornt_pkg::*;

  logic               valid;
  logic               ready;
  logic               command;
  logic [FeatW-1:0]   feature_a;
  logic [FeatW-1:0]   feature_b;
  logic [FeatW-1:0]   feature_c;
  logic [TargetW-1:0] target;

  modport source (
    output valid, command, feature_a, feature_b, feature_c, target,
    input  ready
  );

  modport sink (
    input  valid, command, feature_a, feature_b, feature_c, target,
    output ready
  );

endinterface

// ===== rtl/core/ornt_out_if.sv =====
// ----------------------------------------------------------------------------
// ornt_out_if
// output channel: prediction and error, one transaction per item
// ----------------------------------------------------------------------------
interface ornt_out_if;
  import ornt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [PredW-1:0]       prediction;
  logic signed [ErrW-1:0] error;

  modport source (
    output valid, prediction, error,
    input  ready
  );

  modport sink (
    input  valid, prediction, error,
    output ready
  );

endinterface

// ===== rtl/core/ornt_mul.sv =====
// ----------------------------------------------------------------------------
// ornt_mul
// shared 16 x 48 signed multiplier, built from two partial products: low half first, then high half
// ----------------------------------------------------------------------------
module ornt_mul (
  input  logic                             clk_i,
  input  ornt_pkg::mul_ctrl_t              ctrl_i,
  input  logic [ornt_pkg::FeatW-1:0]       a_i,
  input  logic signed [ornt_pkg::WeightW-1:0] b_i,
  output logic signed [ornt_pkg::ProdW-1:0]   prod_o
);
  import ornt_pkg::*;

  localparam int unsigned PpW = FeatW + HalfW + 2;

  logic signed [FeatW:0]     a_s;
  logic signed [HalfW:0]     b_s;
  logic signed [PpW-1:0]     pp;
  logic signed [ProdW-1:0]   pp_ext;
  logic signed [ProdW-1:0]   acc_q;
  logic signed [ProdW-1:0]   acc_d;

  assign a_s = $signed({1'b0, a_i});
  // low half is unsigned, high half carries the sign
  assign b_s = ctrl_i.load_hi ? $signed({b_i[WeightW-1], b_i[WeightW-1:HalfW]})
                              : $signed({1'b0, b_i[HalfW-1:0]});
  assign pp     = a_s * b_s;
  assign pp_ext = {{(ProdW-PpW){pp[PpW-1]}}, pp};

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.load_lo) begin
      acc_d = pp_ext;
    end else if (ctrl_i.load_hi) begin
      acc_d = acc_q + (pp_ext <<< HalfW);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign prod_o = acc_q;

endmodule

// ===== rtl/core/online_relu_neuron_trainer.sv =====
// ----------------------------------------------------------------------------
// online_relu_neuron_trainer
// single relu neuron with online lms weight update on a shared multiplier
// ----------------------------------------------------------------------------
//
//  channel   direction  transaction
//  in_i      sink       command, feature_a..c, target
//  out_o     source     prediction, error
//  cfg       write      step size (cfg_we_i, cfg_wdata_i)
//
//  sequence: a predict item runs the dot product, relu and result; a train item
//  then scales the error by the rate and updates each weight and the bias; every
//  multiply runs two partial products through the one shared multiplier
//  reset: learning rate 164, all weights and bias zero, no pending result
//  stalls: the result sits in an output register, so the next item may be
//  accepted while it waits; the sequencer only holds when a second result
//  is due and the register is still full
//
module online_relu_neuron_trainer #(
  parameter int unsigned NUM_FEATURES = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ornt_pkg::LrW-1:0]    cfg_wdata_i,
  ornt_in_if.sink                     in_i,
  ornt_out_if.source                  out_o
);
  import ornt_pkg::*;

  // feature index, also used as the weight address
  localparam int unsigned IdxW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_FEATURES - 1);
  localparam int unsigned PredFullW = SumW - FracW;
  localparam int unsigned WideW = SumW + 1;

  typedef enum logic [3:0] {
    StIdle,
    StDotLo,
    StDotHi,
    StDotAcc,
    StRelu,
    StResult,
    StRateLo,
    StRateHi,
    StRateAcc,
    StUpdLo,
    StUpdHi,
    StUpdAcc,
    StBias
  } state_e;

  // saturate a wide signed value to the 48-bit weight range
  function automatic logic signed [WeightW-1:0] sat_w(input logic signed [WideW-1:0] v);
    logic signed [WeightW-1:0] r;
    if ((&v[WideW-1:WeightW-1]) || !(|v[WideW-1:WeightW-1])) begin
      r = v[WeightW-1:0];
    end else if (v[WideW-1]) begin
      r = {1'b1, {(WeightW-1){1'b0}}};
    end else begin
      r = {1'b0, {(WeightW-1){1'b1}}};
    end
    return r;
  endfunction

  state_e                    state_q;
  logic [IdxW-1:0]           idx_q;
  logic [LrW-1:0]            lr_q;

  // item held for the whole sequence
  logic                      cmd_q;
  logic [FeatW-1:0]          fa_q;
  logic [FeatW-1:0]          fb_q;
  logic [FeatW-1:0]          fc_q;
  logic [TargetW-1:0]        target_q;

  // neuron state
  logic signed [WeightW-1:0] weight_q [NUM_FEATURES];
  logic signed [WeightW-1:0] bias_q;

  // working registers
  logic signed [SumW-1:0]    sum_q;
  logic signed [WeightW-1:0] e16_q;
  logic signed [WeightW-1:0] re_q;

  // output register
  logic                      out_valid_q;
  logic [PredW-1:0]          pred_q;
  logic signed [ErrW-1:0]    err_q;

  // shared multiplier
  mul_ctrl_t                 mul_ctrl;
  logic [FeatW-1:0]          mul_a;
  logic signed [WeightW-1:0] mul_b;
  logic signed [ProdW-1:0]   prod;
  logic signed [WeightW-1:0] prod_sh;

  logic [FeatW-1:0]          feat_cur;
  logic signed [WeightW-1:0] weight_cur;
  logic signed [SumW-1:0]    relu_d;
  logic [PredFullW-1:0]      pred_full;
  logic [PredW-1:0]          pred_d;
  logic signed [ErrW-1:0]    err_d;
  logic signed [WideW-1:0]   e16_full;
  logic signed [WeightW-1:0] e16_d;
  logic signed [WeightW-1:0] weight_d;
  logic signed [WeightW-1:0] bias_d;
  logic                      in_fire;
  logic                      out_free;
  logic                      res_load;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign res_load = (state_q == StResult) && out_free;

  // features past the third one read as zero
  always_comb begin
    feat_cur = '0;
    if (32'(idx_q) == 32'd0) begin
      feat_cur = fa_q;
    end else if (32'(idx_q) == 32'd1) begin
      feat_cur = fb_q;
    end else if (32'(idx_q) == 32'd2) begin
      feat_cur = fc_q;
    end
  end

  assign weight_cur = weight_q[idx_q];

  // operand routing into the shared unit
  always_comb begin
    mul_ctrl.load_lo = (state_q == StDotLo) || (state_q == StRateLo) ||
                       (state_q == StUpdLo);
    mul_ctrl.load_hi = (state_q == StDotHi) || (state_q == StRateHi) ||
                       (state_q == StUpdHi);
    if ((state_q == StRateLo) || (state_q == StRateHi)) begin
      mul_a = lr_q;
      mul_b = e16_q;
    end else if ((state_q == StDotLo) || (state_q == StDotHi)) begin
      mul_a = feat_cur;
      mul_b = weight_cur;
    end else begin
      mul_a = feat_cur;
      mul_b = re_q;
    end
  end

  ornt_mul u_mul (
    .clk_i  (clk_i),
    .ctrl_i (mul_ctrl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // floor of product / 2^16, the magnitude always stays inside 48 bits
  assign prod_sh = prod[WeightW+FracW-1:FracW];

  // relu, then integer prediction saturated at the top of its range
  assign relu_d    = sum_q[SumW-1] ? '0 : sum_q;
  assign pred_full = sum_q[SumW-1:FracW];
  assign pred_d    = (|pred_full[PredFullW-1:PredW]) ? '1 : pred_full[PredW-1:0];
  // both operands are unsigned 24 bit, so the difference always fits
  assign err_d     = $signed({1'b0, target_q}) - $signed({1'b0, pred_d});

  // scaled error for the update: target in q.16 minus the relu sum
  assign e16_full = $signed({{(WideW-TargetW-FracW){1'b0}}, target_q, {FracW{1'b0}}}) -
                    $signed({sum_q[SumW-1], sum_q});
  assign e16_d    = sat_w(e16_full);

  assign weight_d = sat_w({{(WideW-WeightW){weight_cur[WeightW-1]}}, weight_cur} +
                          {{(WideW-WeightW){prod_sh[WeightW-1]}}, prod_sh});
  assign bias_d   = sat_w({{(WideW-WeightW){bias_q[WeightW-1]}}, bias_q} +
                          {{(WideW-WeightW){re_q[WeightW-1]}}, re_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      lr_q        <= LrReset;
      cmd_q       <= 1'b0;
      fa_q        <= '0;
      fb_q        <= '0;
      fc_q        <= '0;
      target_q    <= '0;
      for (int i = 0; i < NUM_FEATURES; i++) begin
        weight_q[i] <= '0;
      end
      bias_q      <= '0;
      sum_q       <= '0;
      e16_q       <= '0;
      re_q        <= '0;
      out_valid_q <= 1'b0;
      pred_q      <= '0;
      err_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        lr_q <= cfg_wdata_i;
      end

      // a new result replaces one taken downstream in the same cycle
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_fire) begin
            cmd_q    <= in_i.command;
            fa_q     <= in_i.feature_a;
            fb_q     <= in_i.feature_b;
            fc_q     <= in_i.feature_c;
            target_q <= in_i.target;
            sum_q    <= {{(SumW-WeightW){bias_q[WeightW-1]}}, bias_q};
            idx_q    <= '0;
            state_q  <= StDotLo;
          end
        end
        StDotLo: begin
          state_q <= StDotHi;
        end
        StDotHi: begin
          state_q <= StDotAcc;
        end
        StDotAcc: begin
          sum_q <= sum_q + {{(SumW-WeightW){prod_sh[WeightW-1]}}, prod_sh};
          if (idx_q == LastIdx) begin
            state_q <= StRelu;
          end else begin
            idx_q   <= idx_q + IdxW'(1);
            state_q <= StDotLo;
          end
        end
        StRelu: begin
          sum_q   <= relu_d;
          state_q <= StResult;
        end
        StResult: begin
          // hold here while the previous result still waits
          if (out_free) begin
            pred_q      <= pred_d;
            err_q       <= err_d;
            e16_q       <= e16_d;
            if (cmd_q == CmdPredict) begin
              state_q <= StIdle;
            end else begin
              state_q <= StRateLo;
            end
          end
        end
        StRateLo: begin
          state_q <= StRateHi;
        end
        StRateHi: begin
          state_q <= StRateAcc;
        end
        StRateAcc: begin
          re_q    <= prod_sh;
          idx_q   <= '0;
          state_q <= StUpdLo;
        end
        StUpdLo: begin
          state_q <= StUpdHi;
        end
        StUpdHi: begin
          state_q <= StUpdAcc;
        end
        StUpdAcc: begin
          weight_q[idx_q] <= weight_d;
          if (idx_q == LastIdx) begin
            state_q <= StBias;
          end else begin
            idx_q   <= idx_q + IdxW'(1);
            state_q <= StUpdLo;
          end
        end
        StBias: begin
          bias_q  <= bias_d;
          state_q <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_i.ready       = (state_q == StIdle);
  assign out_o.valid      = out_valid_q;
  assign out_o.prediction = pred_q;
  assign out_o.error      = err_q;

endmodule
